/* rtl/core/magma_pkg.sv */
// Shared types, constants and the round substitution for the Magma block encryptor.
// No dependencies; imported by every module of the block.
package magma_pkg;

    localparam int NUM_ROUNDS     = 32;
    localparam int NUM_KEY_WORDS  = 8;
    localparam int KEY_FWD_ROUNDS = 24;
    localparam int ROT_LEFT       = 11;
    localparam int HALF_W         = 32;
    localparam int BLOCK_W        = 64;
    localparam int KEY_IDX_W      = 3;
    localparam int APB_ADDR_W     = 5;

    typedef logic [HALF_W-1:0] t_half;
    typedef logic [NUM_KEY_WORDS-1:0][HALF_W-1:0] t_keys;

    typedef struct packed {
        logic  valid;
        t_half hi;
        t_half lo;
    } t_stage;

    localparam logic [3:0] SBOX [0:7][0:15] = '{
        '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
          4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
        '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
          4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
        '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
          4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
        '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
          4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
        '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
          4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
        '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
          4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
        '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
          4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
        '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
          4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
    };

    function automatic t_half sbox_layer(input t_half x);
        t_half s;
        s = '0;
        for (int n = 0; n < 8; n++) begin
            s[4*n +: 4] = SBOX[n][x[4*n +: 4]];
        end
        return s;
    endfunction

    function automatic logic [KEY_IDX_W-1:0] key_index(input int unsigned rnd);
        logic [4:0] r5;
        r5 = 5'(rnd);
        if (r5 < 5'(KEY_FWD_ROUNDS)) begin
            return r5[KEY_IDX_W-1:0];
        end
        return ~r5[KEY_IDX_W-1:0];
    endfunction

endpackage

/* rtl/core/magma_keys.sv */
// Key word register file behind the APB-style configuration port.
// Depends on magma_pkg.
module magma_keys
    import magma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [HALF_W-1:0]     pwdata,
    output logic [HALF_W-1:0]     prdata,
    output logic                  pready,
    output t_keys                 o_keys
);

    t_keys                r_keys;
    logic [KEY_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = r_keys[idx];
    assign o_keys = r_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else if (wr_en) begin
            r_keys[idx] <= pwdata;
        end
    end

endmodule

/* rtl/core/magma_round.sv */
// One registered Feistel round: key add, S-box layer, rotate, XOR and half swap.
// Depends on magma_pkg.
module magma_round
    import magma_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    input  t_half  i_key,
    output t_stage o_stage
);

    logic  r_valid;
    t_half r_hi;
    t_half r_lo;
    t_half sum;
    t_half sub;
    t_half n_lo;

    assign sum  = i_stage.lo + i_key;
    assign sub  = sbox_layer(sum);
    assign n_lo = i_stage.hi ^ {sub[HALF_W-ROT_LEFT-1:0], sub[HALF_W-1:HALF_W-ROT_LEFT]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= i_stage.lo;
        r_lo <= n_lo;
    end

    assign o_stage = '{valid: r_valid, hi: r_hi, lo: r_lo};

endmodule

/* rtl/core/magma_block_encrypt_top.sv */
// Magma 64-bit block encryptor: 32 pipelined rounds, one register stage per round.
// Throughput one block per cycle, busy never rises; o_done is the valid bit of the last stage.
// The round pipeline sets the latency; each stage holds one key add and S-box layer.
// Synchronous active-low reset clears key words and all stage valid bits.
// Depends on magma_pkg, magma_keys and magma_round.
module magma_block_encrypt_top
    import magma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [BLOCK_W-1:0]    i_plaintext,
    output logic                  o_done,
    output logic [BLOCK_W-1:0]    o_ciphertext,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [HALF_W-1:0]     pwdata,
    output logic [HALF_W-1:0]     prdata,
    output logic                  pready
);

    t_keys  keys;
    t_stage stages [0:NUM_ROUNDS];

    assign busy = 1'b0;

    magma_keys u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_keys  (keys)
    );

    assign stages[0] = '{
        valid: start && !busy,
        hi:    i_plaintext[BLOCK_W-1:HALF_W],
        lo:    i_plaintext[HALF_W-1:0]
    };

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        magma_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (stages[g]),
            .i_key   (keys[key_index(g)]),
            .o_stage (stages[g+1])
        );
    end

    // undo the swap of the last round
    assign o_done       = stages[NUM_ROUNDS].valid;
    assign o_ciphertext = {stages[NUM_ROUNDS].lo, stages[NUM_ROUNDS].hi};

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, NUM_ROUNDS))
        else $error("result strobe without a transaction accepted 32 cycles earlier");

    a_start_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##NUM_ROUNDS o_done)
        else $error("accepted transaction lost in the round pipeline");

    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_done)
        else $error("result strobe straight after reset");

    a_key_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready) ##1 (psel && !pwrite && paddr == $past(paddr))
        |-> prdata == $past(pwdata))
        else $error("key word read back differs from the value written");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for magma_block_encrypt_top: block transactions checked against a local Magma model.
// Depends on magma_pkg and the RTL under rtl/core; key words are written and read over APB.
module tb_top
    import magma_pkg::*;
();

    localparam int          CLK_HIGH        = 4;
    localparam int          CLK_LOW         = 4;
    localparam int          RST_CYCLES      = 4;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          PRINT_LIMIT     = 100;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          BLOCKS_PER_PHASE = 200;
    localparam logic [31:0] WORD_ONES       = 32'hffff_ffff;
    localparam logic [63:0] KAT_PLAINTEXT   = 64'hfedc_ba98_7654_3210;
    localparam logic [63:0] KAT_CIPHERTEXT  = 64'h4ee9_01e5_c2d8_ca3d;

    localparam logic [3:0] SUBST_TABLE [8][16] = '{
        '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
          4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
        '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
          4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
        '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
          4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
        '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
          4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
        '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
          4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
        '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
          4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
        '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
          4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
        '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
          4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
    };

    localparam logic [31:0] GOST_KEY [NUM_KEY_WORDS] = '{
        32'hffeeddcc, 32'hbbaa9988, 32'h77665544, 32'h33221100,
        32'hf0f1f2f3, 32'hf4f5f6f7, 32'hf8f9fafb, 32'hfcfdfeff
    };

    localparam logic [63:0] EDGE_BLOCKS [8] = '{
        64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
        64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
        64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000,
        64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555
    };

    typedef struct {
        logic [63:0] plaintext;
        logic [63:0] ciphertext;
    } t_block_txn;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [BLOCK_W-1:0]    i_plaintext = '0;
    logic                  o_done;
    logic [BLOCK_W-1:0]    o_ciphertext;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [HALF_W-1:0]     pwdata = '0;
    logic [HALF_W-1:0]     prdata;
    logic                  pready;

    logic [31:0]           key_words [NUM_KEY_WORDS];
    t_block_txn            ciphertext_q [$];
    t_block_txn            oldest_txn;
    int unsigned           error_count = 0;
    int unsigned           cycle_count = 0;

    magma_block_encrypt_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_plaintext  (i_plaintext),
        .o_done       (o_done),
        .o_ciphertext (o_ciphertext),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic logic [31:0] round_mix(input logic [31:0] half, input logic [31:0] kw);
        logic [31:0] sum;
        logic [31:0] sub;
        sum = half + kw;
        sub = '0;
        for (int n = 0; n < 8; n++) begin
            sub[4*n +: 4] = SUBST_TABLE[n][sum[4*n +: 4]];
        end
        return {sub[20:0], sub[31:21]};
    endfunction

    function automatic logic [63:0] magma_encrypt(input logic [63:0] blk);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] mixed;
        logic [31:0] kw;
        hi = blk[63:32];
        lo = blk[31:0];
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            kw = (r < KEY_FWD_ROUNDS) ? key_words[r % NUM_KEY_WORDS]
                                      : key_words[NUM_ROUNDS - 1 - r];
            mixed = hi ^ round_mix(lo, kw);
            if (r < NUM_ROUNDS - 1) begin
                hi = lo;
                lo = mixed;
            end else begin
                hi = mixed;
            end
        end
        return {hi, lo};
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (ciphertext_q.size() == 0) begin
                report_mismatch($sformatf("unexpected ciphertext %h", o_ciphertext));
            end else begin
                oldest_txn = ciphertext_q.pop_front();
                if (o_ciphertext !== oldest_txn.ciphertext) begin
                    report_mismatch($sformatf("plaintext %h: ciphertext %h, expected %h",
                                              oldest_txn.plaintext, o_ciphertext,
                                              oldest_txn.ciphertext));
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_key_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick_block();
        logic [63:0] blk;
        blk = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0: blk[63:32] = '0;
            1: blk[63:32] = WORD_ONES;
            2: blk[31:0] = '0;
            3: blk[31:0] = WORD_ONES;
            default: ;
        endcase
        return blk;
    endfunction

    // call at a rising edge; leaves start high when no gap follows
    task automatic send_block(input logic [63:0] pt, input int unsigned gap);
        start <= 1'b1;
        i_plaintext <= pt;
        do @(posedge i_clk); while (busy);
        ciphertext_q.push_back('{plaintext: pt, ciphertext: magma_encrypt(pt)});
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (ciphertext_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_access(input int unsigned idx, input logic wr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= APB_ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr) begin
            key_words[idx] = value;
        end else if (prdata !== key_words[idx]) begin
            report_mismatch($sformatf("key word %0d read %h, expected %h",
                                      idx, prdata, key_words[idx]));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_key(input logic [31:0] words [NUM_KEY_WORDS]);
        for (int i = 0; i < NUM_KEY_WORDS; i++) begin
            apb_access(i, 1'b1, words[i]);
        end
        for (int i = 0; i < NUM_KEY_WORDS; i++) begin
            apb_access(i, 1'b0, '0);
        end
    endtask

    task automatic test_reset_key();
        for (int i = 0; i < NUM_KEY_WORDS; i++) begin
            apb_access(i, 1'b0, '0);
        end
        foreach (EDGE_BLOCKS[i]) begin
            send_block(EDGE_BLOCKS[i], (i % 2 == 0) ? 0 : 2);
        end
        wait_drain();
    endtask

    task automatic test_known_answer();
        load_key(GOST_KEY);
        if (magma_encrypt(KAT_PLAINTEXT) !== KAT_CIPHERTEXT) begin
            report_mismatch("model disagrees with the standard test vector");
        end
        send_block(KAT_PLAINTEXT, 0);
        wait_drain();
    endtask

    task automatic test_key_extremes();
        logic [31:0] words [NUM_KEY_WORDS];
        for (int i = 0; i < NUM_KEY_WORDS; i++) begin
            words[i] = WORD_ONES;
        end
        load_key(words);
        foreach (EDGE_BLOCKS[i]) begin
            send_block(EDGE_BLOCKS[i], 0);
        end
        wait_drain();
        for (int i = 0; i < NUM_KEY_WORDS; i++) begin
            words[i] = (i % 2 == 0) ? '0 : WORD_ONES;
        end
        load_key(words);
        foreach (EDGE_BLOCKS[i]) begin
            send_block(EDGE_BLOCKS[i], pick_gap());
        end
        wait_drain();
    endtask

    task automatic test_random_traffic();
        logic [31:0] words [NUM_KEY_WORDS];
        int unsigned burst_left;
        int unsigned pause_at;
        logic        idle_free;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int i = 0; i < NUM_KEY_WORDS; i++) begin
                words[i] = pick_key_word();
            end
            load_key(words);
            burst_left = 0;
            idle_free = 1'b0;
            pause_at = $urandom_range(20, BLOCKS_PER_PHASE - 20);
            for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    idle_free = ($urandom_range(0, 2) == 0);
                end
                burst_left--;
                if (n == pause_at) begin
                    wait_drain();
                end
                send_block(pick_block(), idle_free ? 0 : pick_gap());
            end
            wait_drain();
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_KEY_WORDS; i++) begin
            key_words[i] = '0;
        end
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_known_answer();
        test_key_extremes();
        test_random_traffic();

        wait_drain();
        repeat (NUM_ROUNDS + 8) @(posedge i_clk);
        if (ciphertext_q.size() != 0) begin
            report_mismatch($sformatf("%0d ciphertexts never arrived", ciphertext_q.size()));
        end
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
